FILE: sv/hlfr_pkg.sv
// Package for the length-delimited HDLC frame receiver.
// Receive phase type, result kinds, input commands and FCS-16 constants.
// No dependencies.
`default_nettype none

package hlfr_pkg;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_FIRST  = 3'd1,
		PH_SECOND = 3'd2,
		PH_BODY   = 3'd3,
		PH_CLOSE  = 3'd4
	} phase_t;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] FCS_POLY   = 16'h8408;
	localparam logic [15:0] FCS_GOOD   = 16'hF0B8;
	localparam logic [7:0]  PROD_MARK  = 8'hBC;
	localparam logic [2:0]  LEN_HI_MASK = 3'h7;

	localparam logic [0:0]  REG_TIMEOUT = 1'b0;
	localparam logic [0:0]  REG_PROD    = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

endpackage

`default_nettype wire

FILE: sv/hlfr_fcs16.sv
// Byte-wide update of the reflected FCS-16 (polynomial 0x8408).
// Depends on hlfr_pkg.
`default_nettype none

module hlfr_fcs16 (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  byte_in,
	output logic      [15:0] crc_out
);
	import hlfr_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, byte_in};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

FILE: sv/hdlc_length_frame_receiver.sv
// Length-delimited HDLC frame receiver, top level.
// Depends on hlfr_pkg and hlfr_fcs16.
//
// Usage:
//   Input channel (in_valid / in_stall): command 0 carries one received byte
//   in rx_byte, command 1 is one timer tick. Output channel (out_valid /
//   out_stall): zero or one result per item: a stored frame byte with its
//   position, a good frame end, or a discarded frame; frame_length gives the
//   length known so far.
//   Config: cfg_we with cfg_index 0 writes timeout_ticks, index 1 writes
//   production_mode (bit 0). Write only while no item is in flight.
//   Timing: an accepted item waits in the input register; the phase/FCS
//   logic then writes its result into the result register, from which it
//   is taken while out_stall is low.
//   Throughput: one item per cycle while no held result is stalled; the
//   byte-wide FCS update and the phase logic sit in a single stage.
//   Reset: hunting for a flag, idle timer expired, timeout_ticks 500,
//   production mode off, no result pending.
//   Stall: a held result keeps the processing stage waiting; one more item
//   is held in the input register, then in_stall rises.
`default_nettype none

module hdlc_length_frame_receiver #(
	parameter int BUFFER_SIZE = 1024,
	parameter int FLAG_BYTE   = 126
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  kind,
	output logic      [7:0]  data,
	output logic      [10:0] position,
	output logic      [10:0] frame_length,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import hlfr_pkg::*;

	localparam logic [11:0] BUF_LIM = 12'(BUFFER_SIZE);
	localparam logic [7:0]  FLAG    = 8'(FLAG_BYTE);

	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [10:0] count_q, count_d;
	logic [10:0] len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] timer_q, timer_d;
	logic [15:0] tmo_q;
	logic        prod_q;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  data_q;
	logic [10:0] pos_q;
	logic [10:0] flen_q;

	logic        advance, take;
	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_data;
	logic [10:0] res_pos;
	logic [15:0] fcs_in, fcs_out;
	logic [15:0] timer_dec;
	logic        is_flag;
	logic [10:0] len_second;
	logic [10:0] count_inc;

	assign advance  = !out_valid_q || !out_stall;
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign is_flag    = (byte_s1 == FLAG);
	assign timer_dec  = (timer_q != 16'd0) ? timer_q - 16'd1 : 16'd0;
	assign len_second = len_q | {3'b000, byte_s1};
	assign count_inc  = count_q + 11'd1;
	assign fcs_in     = (phase_q == PH_FIRST) ? CRC_PRESET : crc_q;

	hlfr_fcs16 u_fcs (
		.crc_in  (fcs_in),
		.byte_in (byte_s1),
		.crc_out (fcs_out)
	);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (cmd_s1 == CMD_TICK) begin
			if (timer_dec == 16'd0) begin
				phase_d = PH_HUNT;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (is_flag) phase_d = PH_FIRST;
				end
				PH_FIRST: begin
					if (!is_flag) phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					if ({1'b0, len_second} < BUF_LIM) phase_d = PH_BODY;
					else phase_d = PH_HUNT;
				end
				PH_BODY: begin
					if (count_inc >= len_q) phase_d = PH_CLOSE;
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		count_d   = count_q;
		len_d     = len_q;
		crc_d     = crc_q;
		timer_d   = timer_q;
		res_valid = 1'b0;
		res_kind  = KIND_BYTE;
		res_data  = 8'h00;
		res_pos   = 11'd0;
		if (cmd_s1 == CMD_TICK) begin
			timer_d = timer_dec;
			if (timer_dec == 16'd0 && (phase_q == PH_SECOND || phase_q == PH_BODY ||
					phase_q == PH_CLOSE)) begin
				res_valid = 1'b1;
				res_kind  = KIND_DISCARD;
			end
		end else begin
			timer_d = tmo_q;
			case (phase_q)
				PH_HUNT: begin
				end
				PH_FIRST: begin
					if (!is_flag) begin
						count_d = 11'd1;
						crc_d   = fcs_out;
						if (prod_q && byte_s1 == PROD_MARK) len_d = 11'd0;
						else len_d = {byte_s1[2:0] & LEN_HI_MASK, 8'h00};
						res_valid = 1'b1;
						res_data  = byte_s1;
					end
				end
				PH_SECOND: begin
					len_d     = len_second;
					res_valid = 1'b1;
					if ({1'b0, len_second} < BUF_LIM) begin
						count_d = 11'd2;
						if (len_second == 11'd0) crc_d = CRC_PRESET;
						else if (len_second != 11'd1) crc_d = fcs_out;
						res_data = byte_s1;
						res_pos  = 11'd1;
					end else begin
						res_kind = KIND_DISCARD;
					end
				end
				PH_BODY: begin
					if (count_q < len_q) crc_d = fcs_out;
					count_d   = count_inc;
					res_valid = 1'b1;
					res_data  = byte_s1;
					res_pos   = count_q;
				end
				PH_CLOSE: begin
					timer_d   = 16'd0;
					res_valid = 1'b1;
					if (is_flag && crc_q == FCS_GOOD) res_kind = KIND_GOOD;
					else res_kind = KIND_DISCARD;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= command;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 11'd0;
			len_q   <= 11'd0;
			crc_q   <= CRC_PRESET;
			timer_q <= 16'd0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			timer_q <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q  <= TIMEOUT_RESET;
			prod_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: tmo_q <= cfg_data;
				REG_PROD:    prod_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			kind_q <= res_kind;
			data_q <= res_data;
			pos_q  <= res_pos;
			flen_q <= len_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data         = data_q;
	assign position     = pos_q;
	assign frame_length = flen_q;

	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_BYTE |-> data_q == 8'h00 && pos_q == 11'd0)
		else $error("frame end result carries data or position");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with no held item");

	a_close_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_s1 == CMD_BYTE && phase_q == PH_CLOSE |=>
		phase_q == PH_HUNT && timer_q == 16'd0 && out_valid_q)
		else $error("closing byte did not end the frame");

	a_body_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> {1'b0, len_q} < BUF_LIM)
		else $error("frame body with oversize length");

endmodule

`default_nettype wire
